@@ src/bpdt_pkg.sv @@
package bpdt_pkg;

  localparam logic [7:0] TRK_BYTE0   = 8'h4C;
  localparam logic [7:0] TRK_BYTE1   = 8'h00;
  localparam logic [7:0] TRK_BYTE2   = 8'h12;
  localparam logic [4:0] TRK_MIN_LEN = 5'd4;

  localparam logic MODE_SCAN_START = 1'b0;
  localparam logic MODE_PEER       = 1'b1;

  localparam logic REG_SCAN_ENABLE    = 1'b0;
  localparam logic REG_MONITOR_ENABLE = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_FINISH
  } top_state_t;

  typedef enum logic {
    TW_IDLE,
    TW_SCAN
  } walk_state_t;

  typedef struct packed {
    logic        clear;
    logic        start;
    logic        enable;
    logic [47:0] addr;
    logic [7:0]  rssi;
  } walk_req_t;

  typedef struct packed {
    logic done;
    logic changed;
  } walk_rsp_t;

endpackage

@@ src/ble_peer_dedup_table_top.sv @@
// Keeps a table of all advertising devices and a table of tracker devices, each
// deduplicated by 48-bit address, and returns one result item per input item.
// Each table sits in a single-port memory walked linearly, one stored entry
// compared per cycle, and both tables are walked side by side. A peer item that
// misses walks every stored entry of the tables it walks, and a hit ends the
// walk at the matching entry. A scan-start item, or a peer item with both
// tables disabled, walks no table. The input side is stalled while an item is
// in progress, and the next item can be accepted in the cycle in which the
// result appears.
module ble_peer_dedup_table_top #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,

  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic               mode,
  input  logic [47:0]        peer_address,
  input  logic signed [7:0]  signal_strength,
  input  logic [7:0]         company_low,
  input  logic [7:0]         company_high,
  input  logic [7:0]         advert_type,
  input  logic [4:0]         manuf_length,

  output logic               out_valid,
  input  logic               out_stall,
  output logic               list_changed,
  output logic [6:0]         all_count,
  output logic [6:0]         tracker_count,
  output logic               is_tracker
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic scan_enable;
  logic monitor_enable;

  bpdt_pkg::top_state_t state;
  bpdt_pkg::top_state_t state_next;

  logic        item_mode;
  logic [47:0] item_addr;
  logic [7:0]  item_rssi;
  logic        item_tracker;
  logic        all_done;
  logic        trk_done;
  logic        changed;

  logic        accept;
  logic        load_out;
  logic        sig_match;

  bpdt_pkg::walk_req_t all_req;
  bpdt_pkg::walk_req_t trk_req;
  bpdt_pkg::walk_rsp_t all_rsp;
  bpdt_pkg::walk_rsp_t trk_rsp;
  logic [CNT_W-1:0]    all_fill;
  logic [CNT_W-1:0]    trk_fill;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_enable    <= 1'b0;
      monitor_enable <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        bpdt_pkg::REG_SCAN_ENABLE:    scan_enable    <= pwdata[0];
        bpdt_pkg::REG_MONITOR_ENABLE: monitor_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      bpdt_pkg::REG_SCAN_ENABLE:    prdata = {31'd0, scan_enable};
      bpdt_pkg::REG_MONITOR_ENABLE: prdata = {31'd0, monitor_enable};
      default:                      prdata = 32'd0;
    endcase
  end

  assign sig_match = (manuf_length >= bpdt_pkg::TRK_MIN_LEN) &&
                     (company_low == bpdt_pkg::TRK_BYTE0) &&
                     (company_high == bpdt_pkg::TRK_BYTE1) &&
                     (advert_type == bpdt_pkg::TRK_BYTE2);

  always_comb begin
    state_next = state;
    case (state)
      bpdt_pkg::S_IDLE:   if (in_valid) state_next = bpdt_pkg::S_START;
      bpdt_pkg::S_START:  state_next = bpdt_pkg::S_WAIT;
      bpdt_pkg::S_WAIT:   if (all_done && trk_done) state_next = bpdt_pkg::S_FINISH;
      bpdt_pkg::S_FINISH: if (!out_valid || !out_stall) state_next = bpdt_pkg::S_IDLE;
      default:            state_next = bpdt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != bpdt_pkg::S_IDLE);
    accept   = in_valid && !in_stall;
    load_out = (state == bpdt_pkg::S_FINISH) && (!out_valid || !out_stall);

    all_req.clear  = (state == bpdt_pkg::S_START) && (item_mode == bpdt_pkg::MODE_SCAN_START);
    all_req.start  = (state == bpdt_pkg::S_START) && (item_mode == bpdt_pkg::MODE_PEER);
    all_req.enable = scan_enable || monitor_enable;
    all_req.addr   = item_addr;
    all_req.rssi   = item_rssi;

    trk_req.clear  = all_req.clear;
    trk_req.start  = all_req.start;
    trk_req.enable = monitor_enable && item_tracker;
    trk_req.addr   = item_addr;
    trk_req.rssi   = item_rssi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bpdt_pkg::S_IDLE;
      all_done <= 1'b0;
      trk_done <= 1'b0;
      changed  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        all_done <= 1'b0;
        trk_done <= 1'b0;
        changed  <= (mode == bpdt_pkg::MODE_SCAN_START);
      end else begin
        if (all_rsp.done) begin
          all_done <= 1'b1;
        end
        if (trk_rsp.done) begin
          trk_done <= 1'b1;
        end
        if ((all_rsp.done && all_rsp.changed) || (trk_rsp.done && trk_rsp.changed)) begin
          changed <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_mode    <= mode;
      item_addr    <= peer_address;
      item_rssi    <= signal_strength;
      item_tracker <= (mode == bpdt_pkg::MODE_PEER) && sig_match;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      list_changed  <= changed;
      all_count     <= 7'(all_fill);
      tracker_count <= 7'(trk_fill);
      is_tracker    <= item_tracker;
    end
  end

  bpdt_table #(
    .DEPTH (TABLE_DEPTH)
  ) u_all_table (
    .clk  (clk),
    .rst  (rst),
    .req  (all_req),
    .rsp  (all_rsp),
    .fill (all_fill)
  );

  bpdt_table #(
    .DEPTH (TABLE_DEPTH)
  ) u_trk_table (
    .clk  (clk),
    .rst  (rst),
    .req  (trk_req),
    .rsp  (trk_rsp),
    .fill (trk_fill)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (all_fill <= CNT_W'(TABLE_DEPTH)) && (trk_fill <= CNT_W'(TABLE_DEPTH)))
    else $error("table fill count above depth");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == bpdt_pkg::S_FINISH))
    else $error("result item appeared without a finished walk");

  a_finish_delivers: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (out_valid && (state == bpdt_pkg::S_IDLE)))
    else $error("finished item was not delivered");

  a_tracker_subset: assert property (@(posedge clk) disable iff (rst)
    (is_tracker && out_valid) |-> !list_changed || (tracker_count <= all_count) ||
    (7'(TABLE_DEPTH) < all_count) || (CNT_W > 7))
    else $error("tracker table grew past the all-devices table");

endmodule

@@ src/bpdt_table.sv @@
module bpdt_table #(
  parameter int DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bpdt_pkg::walk_req_t          req,
  output bpdt_pkg::walk_rsp_t          rsp,
  output logic [$clog2(DEPTH+1)-1:0]   fill
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [47:0] addr_mem [DEPTH];
  logic [7:0]  str_mem  [DEPTH];

  bpdt_pkg::walk_state_t state;
  bpdt_pkg::walk_state_t state_next;

  logic [CNT_W-1:0] rd_idx;
  logic             cmp_valid;
  logic [IDX_W-1:0] cmp_idx;
  logic [47:0]      key_addr;
  logic [7:0]       key_str;
  logic [47:0]      rd_addr_q;
  logic [7:0]       rd_str_q;

  logic             hit;
  logic             miss;
  logic             has_room;
  logic             rd_en;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;

  assign hit      = (state == bpdt_pkg::TW_SCAN) && cmp_valid && (rd_addr_q == key_addr);
  assign miss     = (state == bpdt_pkg::TW_SCAN) && !cmp_valid && (rd_idx >= fill);
  assign has_room = fill < CNT_W'(DEPTH);
  assign rd_en    = (state == bpdt_pkg::TW_SCAN) && !hit && (rd_idx < fill);

  always_comb begin
    state_next = state;
    case (state)
      bpdt_pkg::TW_IDLE: begin
        if (req.start && req.enable && !req.clear) begin
          state_next = bpdt_pkg::TW_SCAN;
        end
      end
      bpdt_pkg::TW_SCAN: begin
        if (hit || miss) begin
          state_next = bpdt_pkg::TW_IDLE;
        end
      end
      default: state_next = bpdt_pkg::TW_IDLE;
    endcase
  end

  always_comb begin
    wr_en       = hit || (miss && has_room);
    wr_idx      = hit ? cmp_idx : fill[IDX_W-1:0];
    rsp.done    = ((state == bpdt_pkg::TW_IDLE) &&
                   (req.clear || (req.start && !req.enable))) || hit || miss;
    rsp.changed = hit ? (rd_str_q != key_str) : (miss && has_room);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bpdt_pkg::TW_IDLE;
      fill      <= '0;
      rd_idx    <= '0;
      cmp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == bpdt_pkg::TW_IDLE) && req.clear) begin
        fill <= '0;
      end else if (miss && has_room) begin
        fill <= fill + CNT_W'(1);
      end
      if (state == bpdt_pkg::TW_IDLE) begin
        rd_idx    <= '0;
        cmp_valid <= 1'b0;
      end else begin
        cmp_valid <= rd_en;
        if (rd_en) begin
          rd_idx <= rd_idx + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == bpdt_pkg::TW_IDLE) && req.start) begin
      key_addr <= req.addr;
      key_str  <= req.rssi;
    end
    if (rd_en) begin
      cmp_idx <= rd_idx[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      addr_mem[wr_idx] <= key_addr;
      str_mem[wr_idx]  <= key_str;
    end
    if (rd_en) begin
      rd_addr_q <= addr_mem[rd_idx[IDX_W-1:0]];
      rd_str_q  <= str_mem[rd_idx[IDX_W-1:0]];
    end
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  localparam int DEPTH        = 64;
  localparam int RANDOM_ITEMS = 2000;
  localparam int LONG_HOLD    = 500;

  typedef struct packed {
    logic        mode;
    logic [47:0] addr;
    logic [7:0]  rssi;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [4:0]  len;
  } peer_item_t;

  typedef struct packed {
    logic       changed;
    logic [6:0] all_n;
    logic [6:0] trk_n;
    logic       tracker;
  } dedup_result_t;

  typedef struct packed {
    logic          set_cfg;
    logic          scan_on;
    logic          mon_on;
    peer_item_t    item;
    logic          typed;
    dedup_result_t want;
  } stim_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        mode = bpdt_pkg::MODE_SCAN_START;
  logic [47:0] peer_address = '0;
  logic signed [7:0] signal_strength = '0;
  logic [7:0]  company_low = '0;
  logic [7:0]  company_high = '0;
  logic [7:0]  advert_type = '0;
  logic [4:0]  manuf_length = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        list_changed;
  logic [6:0]  all_count;
  logic [6:0]  tracker_count;
  logic        is_tracker;

  ble_peer_dedup_table_top #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
    .peer_address(peer_address), .signal_strength(signal_strength),
    .company_low(company_low), .company_high(company_high),
    .advert_type(advert_type), .manuf_length(manuf_length),
    .out_valid(out_valid), .out_stall(out_stall), .list_changed(list_changed),
    .all_count(all_count), .tracker_count(tracker_count), .is_tracker(is_tracker)
  );

  // Predictor copy of the tables: index 0 is all devices, index 1 is trackers.
  logic [47:0]   table_addr [2][DEPTH];
  logic [7:0]    table_rssi [2][DEPTH];
  int            table_fill [2];
  int            table_peak [2];
  bit            scan_on_q;
  bit            mon_on_q;

  dedup_result_t expected_results[$];
  dedup_result_t head_result;
  stim_row_t     directed_rows[$];

  int  errors = 0;
  int  items_sent = 0;
  int  results_checked = 0;
  int  clears_seen = 0;
  int  tracker_peers = 0;
  int  full_drops = 0;
  int  config_writes = 0;
  int  backpressure_cycles = 0;

  bit  quiet_pace = 1'b0;
  int  hold_request = 0;
  int  hold_left = 0;
  int  run_left = 0;
  bit  run_stalled = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Timed out with %0d results outstanding.", expected_results.size());
    $display("** ble_peer_dedup_table_top: FAILED **");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void add_row(stim_row_t row);
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  function automatic void add_expected(dedup_result_t res);
    expected_results.insert(expected_results.size(), res);
  endfunction

  function automatic peer_item_t mk_item(logic md, logic [47:0] addr, logic [7:0] rssi,
                                         logic [4:0] len, logic [7:0] b0, logic [7:0] b1,
                                         logic [7:0] b2);
    peer_item_t it;
    it.mode = md;
    it.addr = addr;
    it.rssi = rssi;
    it.len  = len;
    it.b0   = b0;
    it.b1   = b1;
    it.b2   = b2;
    return it;
  endfunction

  function automatic dedup_result_t mk_result(logic c, int a, int t, logic k);
    dedup_result_t r;
    r.changed = c;
    r.all_n   = 7'(a);
    r.trk_n   = 7'(t);
    r.tracker = k;
    return r;
  endfunction

  function automatic bit update_table(int t, logic [47:0] addr, logic [7:0] rssi);
    bit diff;
    for (int i = 0; i < table_fill[t]; i++) begin
      if (table_addr[t][i] == addr) begin
        diff = table_rssi[t][i] != rssi;
        table_rssi[t][i] = rssi;
        return diff;
      end
    end
    if (table_fill[t] < DEPTH) begin
      table_addr[t][table_fill[t]] = addr;
      table_rssi[t][table_fill[t]] = rssi;
      table_fill[t]++;
      if (table_fill[t] > table_peak[t]) table_peak[t] = table_fill[t];
      return 1'b1;
    end
    full_drops++;
    return 1'b0;
  endfunction

  function automatic dedup_result_t predict_dedup(peer_item_t it);
    dedup_result_t r;
    r = '0;
    if (it.mode == bpdt_pkg::MODE_SCAN_START) begin
      table_fill[0] = 0;
      table_fill[1] = 0;
      r.changed = 1'b1;
      clears_seen++;
    end else begin
      r.tracker = it.len >= bpdt_pkg::TRK_MIN_LEN && it.b0 == bpdt_pkg::TRK_BYTE0 &&
                  it.b1 == bpdt_pkg::TRK_BYTE1 && it.b2 == bpdt_pkg::TRK_BYTE2;
      if (r.tracker) tracker_peers++;
      if (scan_on_q || mon_on_q) begin
        if (update_table(0, it.addr, it.rssi)) r.changed = 1'b1;
      end
      if (mon_on_q && r.tracker) begin
        if (update_table(1, it.addr, it.rssi)) r.changed = 1'b1;
      end
    end
    r.all_n = 7'(table_fill[0]);
    r.trk_n = 7'(table_fill[1]);
    return r;
  endfunction

  task automatic send_item(peer_item_t it, bit typed, dedup_result_t want);
    int gap;
    dedup_result_t predicted;
    gap = quiet_pace ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    mode            <= it.mode;
    peer_address    <= it.addr;
    signal_strength <= it.rssi;
    company_low     <= it.b0;
    company_high    <= it.b1;
    advert_type     <= it.b2;
    manuf_length    <= it.len;
    in_valid        <= 1'b1;
    do @(posedge clk); while (in_stall);
    predicted = predict_dedup(it);
    add_expected(typed ? want : predicted);
    items_sent++;
  endtask

  task automatic go_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write_check(logic idx, bit value);
    logic [31:0] data;
    data = $urandom();
    data[0] = value;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {31'b0, value}) begin
      $display("%0t: register %0d readback: expected %0d, got %0h",
               $time, idx, value, prdata);
      errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(bit scan_on, bit mon_on);
    apb_write_check(bpdt_pkg::REG_SCAN_ENABLE, scan_on);
    apb_write_check(bpdt_pkg::REG_MONITOR_ENABLE, mon_on);
    scan_on_q = scan_on;
    mon_on_q  = mon_on;
    config_writes++;
  endtask

  task automatic check_field(string what, logic [6:0] exp_v, logic [6:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, exp_v, got_v);
      errors++;
    end
  endtask

  always @(negedge clk) begin
    if (hold_left == 0 && hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (quiet_pace) begin
      out_stall <= 1'b0;
    end else begin
      if (run_left == 0) begin
        run_stalled = $urandom_range(0, 99) < 30;
        run_left = run_stalled ? (pick_gap() + 1) : $urandom_range(1, 8);
      end
      run_left--;
      out_stall <= run_stalled;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_stall) backpressure_cycles++;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with no item outstanding: changed %0d all %0d trk %0d",
                 $time, list_changed, all_count, tracker_count);
        errors++;
      end else begin
        head_result = expected_results.pop_front();
        check_field("list_changed", 7'(head_result.changed), 7'(list_changed));
        check_field("all_count", head_result.all_n, all_count);
        check_field("tracker_count", head_result.trk_n, tracker_count);
        check_field("is_tracker", 7'(head_result.tracker), 7'(is_tracker));
        results_checked++;
      end
    end
  end

  initial begin
    int            r;
    int            idx;
    int            pool_n;
    int            phase_len;
    int            phase_no;
    int            noise_pct;
    int            trk_pct;
    bit            new_scan;
    bit            new_mon;
    bit            hold_done;
    logic [47:0]   pool_addr [100];
    bit            pool_trk [100];
    peer_item_t    it;

    table_fill[0] = 0;
    table_fill[1] = 0;
    table_peak[0] = 0;
    table_peak[1] = 0;
    scan_on_q = 1'b0;
    mon_on_q  = 1'b0;
    hold_done = 1'b0;

    // Enables at their reset value: only the signature match is reported.
    add_row('{1'b0, 1'b0, 1'b0,
      mk_item(bpdt_pkg::MODE_SCAN_START, '1, 8'h80, 5'd31, 8'hFF, 8'hFF, 8'hFF),
      1'b1, mk_result(1'b1, 0, 0, 1'b0)});
    add_row('{1'b0, 1'b0, 1'b0,
      mk_item(bpdt_pkg::MODE_PEER, '0, 8'h7F, bpdt_pkg::TRK_MIN_LEN, bpdt_pkg::TRK_BYTE0,
              bpdt_pkg::TRK_BYTE1, bpdt_pkg::TRK_BYTE2),
      1'b1, mk_result(1'b0, 0, 0, 1'b1)});
    add_row('{1'b0, 1'b0, 1'b0,
      mk_item(bpdt_pkg::MODE_PEER, '0, 8'h7F, 5'd3, bpdt_pkg::TRK_BYTE0,
              bpdt_pkg::TRK_BYTE1, bpdt_pkg::TRK_BYTE2),
      1'b1, mk_result(1'b0, 0, 0, 1'b0)});
    add_row('{1'b0, 1'b0, 1'b0,
      mk_item(bpdt_pkg::MODE_PEER, '0, 8'h7F, 5'd31, bpdt_pkg::TRK_BYTE0,
              bpdt_pkg::TRK_BYTE1, bpdt_pkg::TRK_BYTE2),
      1'b1, mk_result(1'b0, 0, 0, 1'b1)});
    add_row('{1'b0, 1'b0, 1'b0,
      mk_item(bpdt_pkg::MODE_PEER, '0, 8'h7F, 5'd24, 8'h4D, bpdt_pkg::TRK_BYTE1,
              bpdt_pkg::TRK_BYTE2),
      1'b1, mk_result(1'b0, 0, 0, 1'b0)});
    // General scan only.
    add_row('{1'b1, 1'b1, 1'b0,
      mk_item(bpdt_pkg::MODE_PEER, '0, 8'h80, 5'd0, 8'h00, 8'h00, 8'h00),
      1'b1, mk_result(1'b1, 1, 0, 1'b0)});
    add_row('{1'b0, 1'b0, 1'b0,
      mk_item(bpdt_pkg::MODE_PEER, '1, 8'h7F, 5'd24, bpdt_pkg::TRK_BYTE0,
              bpdt_pkg::TRK_BYTE1, bpdt_pkg::TRK_BYTE2),
      1'b1, mk_result(1'b1, 2, 0, 1'b1)});
    add_row('{1'b0, 1'b0, 1'b0,
      mk_item(bpdt_pkg::MODE_PEER, '0, 8'h80, 5'd0, 8'h00, 8'h00, 8'h00),
      1'b1, mk_result(1'b0, 2, 0, 1'b0)});
    add_row('{1'b0, 1'b0, 1'b0,
      mk_item(bpdt_pkg::MODE_PEER, '0, 8'h7F, 5'd0, 8'h00, 8'h00, 8'h00),
      1'b1, mk_result(1'b1, 2, 0, 1'b0)});
    // Monitor only.
    add_row('{1'b1, 1'b0, 1'b1,
      mk_item(bpdt_pkg::MODE_PEER, '1, 8'h7F, bpdt_pkg::TRK_MIN_LEN, bpdt_pkg::TRK_BYTE0,
              bpdt_pkg::TRK_BYTE1, bpdt_pkg::TRK_BYTE2),
      1'b1, mk_result(1'b1, 2, 1, 1'b1)});
    add_row('{1'b0, 1'b0, 1'b0,
      mk_item(bpdt_pkg::MODE_PEER, '1, 8'h7F, bpdt_pkg::TRK_MIN_LEN, bpdt_pkg::TRK_BYTE0,
              bpdt_pkg::TRK_BYTE1, bpdt_pkg::TRK_BYTE2),
      1'b1, mk_result(1'b0, 2, 1, 1'b1)});
    add_row('{1'b0, 1'b0, 1'b0,
      mk_item(bpdt_pkg::MODE_PEER, '1, 8'hFF, bpdt_pkg::TRK_MIN_LEN, bpdt_pkg::TRK_BYTE0,
              bpdt_pkg::TRK_BYTE1, bpdt_pkg::TRK_BYTE2),
      1'b1, mk_result(1'b1, 2, 1, 1'b1)});
    add_row('{1'b0, 1'b0, 1'b0,
      mk_item(bpdt_pkg::MODE_PEER, 48'h1234_5678_9ABC, 8'h00, 5'd5, bpdt_pkg::TRK_BYTE0,
              bpdt_pkg::TRK_BYTE1, 8'h13),
      1'b1, mk_result(1'b1, 3, 1, 1'b0)});
    add_row('{1'b0, 1'b0, 1'b0,
      mk_item(bpdt_pkg::MODE_PEER, 48'hA5A5_A5A5_A5A5, 8'h55, 5'd16, bpdt_pkg::TRK_BYTE0,
              8'hFF, bpdt_pkg::TRK_BYTE2),
      1'b0, '0});
    // Both enables on.
    add_row('{1'b1, 1'b1, 1'b1,
      mk_item(bpdt_pkg::MODE_PEER, 48'h8000_0000_0000, 8'h01, 5'd25, bpdt_pkg::TRK_BYTE0,
              bpdt_pkg::TRK_BYTE1, bpdt_pkg::TRK_BYTE2),
      1'b1, mk_result(1'b1, 5, 2, 1'b1)});
    add_row('{1'b0, 1'b0, 1'b0,
      mk_item(bpdt_pkg::MODE_PEER, 48'h8000_0000_0000, 8'h01, 5'd25, bpdt_pkg::TRK_BYTE0,
              bpdt_pkg::TRK_BYTE1, bpdt_pkg::TRK_BYTE2),
      1'b0, '0});
    add_row('{1'b0, 1'b0, 1'b0,
      mk_item(bpdt_pkg::MODE_SCAN_START, '0, 8'h00, 5'd0, 8'h00, 8'h00, 8'h00),
      1'b1, mk_result(1'b1, 0, 0, 1'b0)});
    add_row('{1'b0, 1'b0, 1'b0,
      mk_item(bpdt_pkg::MODE_PEER, '0, 8'h00, 5'd31, 8'hFF, 8'hFF, 8'hFF),
      1'b1, mk_result(1'b1, 1, 0, 1'b0)});
    // Both enables off again: the table keeps its content.
    add_row('{1'b1, 1'b0, 1'b0,
      mk_item(bpdt_pkg::MODE_PEER, 48'h1, 8'h00, bpdt_pkg::TRK_MIN_LEN, bpdt_pkg::TRK_BYTE0,
              bpdt_pkg::TRK_BYTE1, bpdt_pkg::TRK_BYTE2),
      1'b1, mk_result(1'b0, 1, 0, 1'b1)});
    add_row('{1'b0, 1'b0, 1'b0,
      mk_item(bpdt_pkg::MODE_SCAN_START, 48'h5555_5555_5555, 8'hAA, 5'd10, 8'h4C, 8'h00,
              8'h12),
      1'b1, mk_result(1'b1, 0, 0, 1'b0)});

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_cfg) begin
        go_idle();
        set_config(directed_rows[i].scan_on, directed_rows[i].mon_on);
      end
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    end

    phase_no = 0;
    while (items_sent < directed_rows.size() + RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        new_scan = 1'b0;
        new_mon  = 1'b0;
      end else if (r < 30) begin
        new_scan = 1'b1;
        new_mon  = 1'b0;
      end else if (r < 55) begin
        new_scan = 1'b0;
        new_mon  = 1'b1;
      end else begin
        new_scan = 1'b1;
        new_mon  = 1'b1;
      end
      if (phase_no == 0) begin
        new_scan = 1'b1;
        new_mon  = 1'b1;
      end
      if (new_scan != scan_on_q || new_mon != mon_on_q || $urandom_range(0, 3) == 0) begin
        go_idle();
        set_config(new_scan, new_mon);
      end

      r = $urandom_range(0, 99);
      if (phase_no == 0 || r < 35) begin
        pool_n    = $urandom_range(70, 100);
        phase_len = $urandom_range(200, 400);
        noise_pct = 0;
        trk_pct   = 90;
      end else if (r < 50) begin
        pool_n    = $urandom_range(30, 64);
        phase_len = $urandom_range(60, 150);
        noise_pct = 2;
        trk_pct   = 50;
      end else begin
        pool_n    = $urandom_range(1, 16);
        phase_len = $urandom_range(20, 80);
        noise_pct = 3;
        trk_pct   = 50;
      end
      for (int i = 0; i < pool_n; i++) begin
        pool_addr[i] = 48'({$urandom(), $urandom()});
        pool_trk[i]  = $urandom_range(0, 99) < trk_pct;
      end
      quiet_pace = phase_no != 0 && $urandom_range(0, 4) == 0;

      if ($urandom_range(0, 9) < 7) begin
        it = mk_item(bpdt_pkg::MODE_SCAN_START, 48'({$urandom(), $urandom()}),
                     8'($urandom()), 5'($urandom()), 8'($urandom()), 8'($urandom()),
                     8'($urandom()));
        send_item(it, 1'b0, '0);
      end

      for (int k = 0; k < phase_len && items_sent < directed_rows.size() + RANDOM_ITEMS;
           k++) begin
        if (!hold_done && k == 40) begin
          hold_request = LONG_HOLD;
          hold_done = 1'b1;
        end
        idx = $urandom_range(0, pool_n - 1);
        it.mode = ($urandom_range(0, 99) < noise_pct) ? bpdt_pkg::MODE_SCAN_START
                                                      : bpdt_pkg::MODE_PEER;
        it.addr = pool_addr[idx];
        it.rssi = ($urandom_range(0, 1) == 0) ? 8'(8'hC0 + $urandom_range(0, 2))
                                              : 8'($urandom());
        it.b0  = 8'($urandom());
        it.b1  = 8'($urandom());
        it.b2  = 8'($urandom());
        it.len = 5'($urandom());
        r = $urandom_range(0, 99);
        if ((pool_trk[idx] && r < 85) || r < 10) begin
          it.b0  = bpdt_pkg::TRK_BYTE0;
          it.b1  = bpdt_pkg::TRK_BYTE1;
          it.b2  = bpdt_pkg::TRK_BYTE2;
          it.len = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 3))
                                              : 5'($urandom_range(4, 31));
          // Near misses: a single signature byte is disturbed.
          if (!pool_trk[idx] && $urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 2))
              0: it.b0 = 8'($urandom());
              1: it.b1 = 8'($urandom());
              default: it.b2 = 8'($urandom());
            endcase
          end
        end
        send_item(it, 1'b0, '0);
      end

      if ($urandom_range(0, 5) == 0) go_idle();
      phase_no++;
    end

    go_idle();
    repeat (DEPTH + 16) @(posedge clk);

    $display("Checked %0d results over %0d register settings: %0d clears, %0d tracker peers,",
             results_checked, config_writes, clears_seen, tracker_peers);
    $display("%0d drops on a full table, peak fill %0d/%0d, input held back %0d cycles.",
             full_drops, table_peak[0], table_peak[1], backpressure_cycles);
    if (errors == 0) begin
      $display("** ble_peer_dedup_table_top: PASSED **");
    end else begin
      $display("%0d errors.", errors);
      $display("** ble_peer_dedup_table_top: FAILED **");
    end
    $finish;
  end

endmodule

@@ ble_peer_dedup_table_top.f @@
src/bpdt_pkg.sv
src/bpdt_table.sv
src/ble_peer_dedup_table_top.sv
tb/tb_top.sv
